@@ rtl/imhq_pkg.sv @@
// Package for the indexed min-heap queue: sizes, command, status and
// sequencer state types. Depends on nothing; used by the queue module.
package imhq_pkg;

  localparam int CAPACITY     = 1024;
  localparam int HANDLE_BITS  = 10;
  localparam int COUNT_BITS   = 11;
  localparam int KEY_BITS     = 32;
  localparam int PAY_BITS     = 32;
  localparam int IN_DATA_BITS  = 80;
  localparam int OUT_DATA_BITS = 152;

  typedef enum logic [1:0] {
    CMD_INSERT  = 2'd0,
    CMD_EXTRACT = 2'd1,
    CMD_DELETE  = 2'd2,
    CMD_UPDATE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FULL    = 2'd1,
    STAT_EMPTY   = 2'd2,
    STAT_INVALID = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    S_IDLE, S_INS0, S_INS1, S_INS2, S_EXT0, S_EXT1, S_CHK0, S_CHK1, S_CHK2,
    S_X0, S_X1, S_X2, S_U0, S_U1, S_R0, S_R1, S_R2, S_D0, S_D1, S_D2, S_D3,
    S_PLACE, S_MIN0, S_MIN1, S_MIN2, S_FIN
  } state_e;

endpackage

@@ rtl/indexed_min_heap_queue.sv @@
// Indexed binary min-heap queue: one command word in, one result word out.
// One command at a time; the single read ports of the slot and key memories
// set the cost of each sift-up and sift-down level.
// Reset clears the counts and the output valid flag at once; the memories need
// no clearing: a handle is live only if it was issued and its slot points back.
module indexed_min_heap_queue (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: handle[9:0], key[41:10], payload[73:42], zero fill
  input  logic [79:0] s_axis_tdata,
  // tuser: cmd[1:0]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: out_handle[9:0], out_payload[41:10], out_key[73:42], count[84:74],
  // empty_res[85], min_key[117:86], min_payload[149:118], zero fill
  output logic [151:0] m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]  m_axis_tuser
);
  import imhq_pkg::*;

  localparam int HW = HANDLE_BITS;
  localparam int CW = COUNT_BITS;

  state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d, fresh_q, fresh_d, fstk_q, fstk_d;
  cmd_e          cmd_q, cmd_d;
  logic [HW-1:0] hin_q, hin_d, h_q, h_d, pos_q, pos_d, ph_q, ph_d;
  logic [HW-1:0] lh_q, lh_d, rh_q, rh_d, oh_q, oh_d;
  logic [KEY_BITS-1:0] kin_q, kin_d, k_q, k_d, lk_q, lk_d, ok_q, ok_d, mk_q, mk_d;
  logic [PAY_BITS-1:0] pin_q, pin_d, op_q, op_d, mp_q, mp_d;
  logic          moved_q, moved_d;
  status_e       st_q, st_d;
  logic          ov_q, ov_d, load;
  logic [OUT_DATA_BITS-1:0] otd_q, otd_d;
  logic [1:0]    otu_q, otu_d;

  // Memory ports.
  logic                slot_we, posm_we, key_we, pay_we, free_we;
  logic [HW-1:0]       slot_wa, slot_ra, slot_wd, slot_rd;
  logic [HW-1:0]       posm_wa, posm_ra, posm_wd, posm_rd;
  logic [HW-1:0]       key_wa, key_ra, pay_wa, pay_ra;
  logic [KEY_BITS-1:0] key_wd, key_rd;
  logic [PAY_BITS-1:0] pay_wd, pay_rd;
  logic [HW-1:0]       free_wa, free_ra, free_wd, free_rd;

  imhq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_slot (
    .clk_i, .we_i(slot_we), .waddr_i(slot_wa), .wdata_i(slot_wd),
    .raddr_i(slot_ra), .rdata_o(slot_rd));
  imhq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_posm (
    .clk_i, .we_i(posm_we), .waddr_i(posm_wa), .wdata_i(posm_wd),
    .raddr_i(posm_ra), .rdata_o(posm_rd));
  imhq_ram #(.WIDTH(KEY_BITS), .DEPTH(CAPACITY)) u_key (
    .clk_i, .we_i(key_we), .waddr_i(key_wa), .wdata_i(key_wd),
    .raddr_i(key_ra), .rdata_o(key_rd));
  imhq_ram #(.WIDTH(PAY_BITS), .DEPTH(CAPACITY)) u_pay (
    .clk_i, .we_i(pay_we), .waddr_i(pay_wa), .wdata_i(pay_wd),
    .raddr_i(pay_ra), .rdata_o(pay_rd));
  imhq_ram #(.WIDTH(HW), .DEPTH(CAPACITY)) u_free (
    .clk_i, .we_i(free_we), .waddr_i(free_wa), .wdata_i(free_wd),
    .raddr_i(free_ra), .rdata_o(free_rd));

  // Tree arithmetic around the current hole position.
  logic [HW-1:0]   par;
  logic [HW:0]     lft;
  logic [HW+1:0]   rgt;
  logic            has_l, has_r, par_le, sink_stop, full, empty, chk_in, issued;
  logic [HW-1:0]   kid, kpos;
  logic [KEY_BITS-1:0] kk;

  assign par    = HW'((pos_q - HW'(1)) >> 1);
  assign lft    = {pos_q, 1'b1};
  assign rgt    = {1'b0, lft} + (HW+2)'(1);
  assign has_l  = lft < count_q;
  assign has_r  = rgt < {1'b0, count_q};
  assign par_le = key_rd <= k_q;
  assign full   = count_q == CW'(CAPACITY);
  assign empty  = count_q == '0;
  // Handles are issued in order, so one never handed out has no position yet.
  assign issued = {1'b0, hin_q} < fresh_q;
  assign chk_in = issued && ({1'b0, posm_rd} < count_q);

  always_comb begin
    if (state_q == S_D3 && key_rd < lk_q) begin
      kid  = rh_q;
      kk   = key_rd;
      kpos = rgt[HW-1:0];
    end else if (state_q == S_D3) begin
      kid  = lh_q;
      kk   = lk_q;
      kpos = lft[HW-1:0];
    end else begin
      kid  = lh_q;
      kk   = key_rd;
      kpos = lft[HW-1:0];
    end
  end
  assign sink_stop = k_q <= kk;

  assign s_axis_tready = state_q == S_IDLE;
  assign load = state_q == S_FIN && (!ov_q || m_axis_tready);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          case (cmd_e'(s_axis_tuser))
            CMD_INSERT:  state_d = S_INS0;
            CMD_EXTRACT: state_d = S_EXT0;
            default:     state_d = S_CHK0;
          endcase
        end
      end
      S_INS0:  state_d = full ? S_MIN0 : (fstk_q != '0 ? S_INS1 : S_INS2);
      S_INS1:  state_d = S_INS2;
      S_INS2:  state_d = S_R0;
      S_EXT0:  state_d = empty ? S_MIN0 : S_EXT1;
      S_EXT1:  state_d = S_X0;
      S_CHK0:  state_d = S_CHK1;
      S_CHK1:  state_d = chk_in ? S_CHK2 : S_MIN0;
      S_CHK2: begin
        if (slot_rd != hin_q) state_d = S_MIN0;
        else                  state_d = (cmd_q == CMD_DELETE) ? S_X0 : S_U0;
      end
      S_X0:    state_d = S_X1;
      S_X1:    state_d = (slot_rd == oh_q) ? S_MIN0 : S_X2;
      S_X2:    state_d = S_R0;
      S_U0:    state_d = S_U1;
      S_U1:    state_d = S_R0;
      S_R0: begin
        if (pos_q != '0) state_d = S_R1;
        else             state_d = moved_q ? S_PLACE : S_D0;
      end
      S_R1:    state_d = S_R2;
      S_R2: begin
        if (par_le) state_d = moved_q ? S_PLACE : S_D0;
        else        state_d = S_R0;
      end
      S_D0:    state_d = has_l ? S_D1 : S_PLACE;
      S_D1:    state_d = S_D2;
      S_D2: begin
        if (has_r)          state_d = S_D3;
        else if (sink_stop) state_d = S_PLACE;
        else                state_d = S_D0;
      end
      S_D3:    state_d = sink_stop ? S_PLACE : S_D0;
      S_PLACE: state_d = S_MIN0;
      S_MIN0:  state_d = empty ? S_FIN : S_MIN1;
      S_MIN1:  state_d = S_MIN2;
      S_MIN2:  state_d = S_FIN;
      S_FIN:   state_d = load ? S_IDLE : S_FIN;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and memory control.
  always_comb begin
    count_d = count_q;  fresh_d = fresh_q;  fstk_d = fstk_q;
    cmd_d = cmd_q;  hin_d = hin_q;  kin_d = kin_q;  pin_d = pin_q;
    h_d = h_q;  k_d = k_q;  pos_d = pos_q;  ph_d = ph_q;
    lh_d = lh_q;  rh_d = rh_q;  lk_d = lk_q;  moved_d = moved_q;
    st_d = st_q;  oh_d = oh_q;  ok_d = ok_q;  op_d = op_q;
    mk_d = mk_q;  mp_d = mp_q;
    slot_we = 1'b0; slot_wa = '0; slot_wd = '0; slot_ra = '0;
    posm_we = 1'b0; posm_wa = '0; posm_wd = '0; posm_ra = '0;
    key_we = 1'b0;  key_wa = '0;  key_wd = '0;  key_ra = '0;
    pay_we = 1'b0;  pay_wa = '0;  pay_wd = '0;  pay_ra = '0;
    free_we = 1'b0; free_wa = '0; free_wd = '0; free_ra = '0;
    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d   = cmd_e'(s_axis_tuser);
          hin_d   = s_axis_tdata[9:0];
          kin_d   = s_axis_tdata[41:10];
          pin_d   = s_axis_tdata[73:42];
          st_d    = STAT_OK;
          oh_d    = '0;
          ok_d    = '0;
          op_d    = '0;
          moved_d = 1'b0;
        end
      end
      S_INS0: begin
        // Freed handles are reused first, newest first; then fresh ones in order.
        if (full) begin
          st_d = STAT_FULL;
        end else if (fstk_q != '0) begin
          free_ra = HW'(fstk_q - CW'(1));
          fstk_d  = fstk_q - CW'(1);
        end else begin
          h_d     = fresh_q[HW-1:0];
          fresh_d = fresh_q + CW'(1);
        end
      end
      S_INS1: h_d = free_rd;
      S_INS2: begin
        key_we = 1'b1; key_wa = h_q; key_wd = kin_q;
        pay_we = 1'b1; pay_wa = h_q; pay_wd = pin_q;
        k_d     = kin_q;
        pos_d   = count_q[HW-1:0];
        count_d = count_q + CW'(1);
        oh_d    = h_q;
      end
      S_EXT0: begin
        if (empty) st_d = STAT_EMPTY;
      end
      S_EXT1: begin
        oh_d  = slot_rd;
        pos_d = '0;
      end
      S_CHK0: posm_ra = hin_q;
      S_CHK1: begin
        // A handle is live when it was issued and its recorded slot is in use and points back.
        pos_d   = posm_rd;
        slot_ra = posm_rd;
        if (!chk_in) st_d = STAT_INVALID;
      end
      S_CHK2: begin
        if (slot_rd == hin_q) oh_d = hin_q;
        else                  st_d = STAT_INVALID;
      end
      S_X0: begin
        key_ra  = oh_q;
        pay_ra  = oh_q;
        slot_ra = HW'(count_q - CW'(1));
      end
      S_X1: begin
        ok_d    = key_rd;
        op_d    = pay_rd;
        count_d = count_q - CW'(1);
        free_we = 1'b1; free_wa = fstk_q[HW-1:0]; free_wd = oh_q;
        fstk_d  = fstk_q + CW'(1);
        h_d     = slot_rd;
        key_ra  = slot_rd;
      end
      S_X2: k_d = key_rd;
      S_U0: begin
        key_ra = hin_q;
        pay_ra = hin_q;
      end
      S_U1: begin
        ok_d = key_rd;
        op_d = pay_rd;
        key_we = 1'b1; key_wa = hin_q; key_wd = kin_q;
        pay_we = 1'b1; pay_wa = hin_q; pay_wd = pin_q;
        h_d = hin_q;
        k_d = kin_q;
      end
      S_R0: slot_ra = par;
      S_R1: begin
        ph_d   = slot_rd;
        key_ra = slot_rd;
      end
      S_R2: begin
        // The parent drops into the hole and the hole moves up one level.
        if (!par_le) begin
          slot_we = 1'b1; slot_wa = pos_q; slot_wd = ph_q;
          posm_we = 1'b1; posm_wa = ph_q;  posm_wd = pos_q;
          pos_d   = par;
          moved_d = 1'b1;
        end
      end
      S_D0: slot_ra = lft[HW-1:0];
      S_D1: begin
        lh_d    = slot_rd;
        key_ra  = slot_rd;
        slot_ra = rgt[HW-1:0];
      end
      S_D2: begin
        lk_d   = key_rd;
        rh_d   = slot_rd;
        key_ra = slot_rd;
        if (!has_r && !sink_stop) begin
          slot_we = 1'b1; slot_wa = pos_q; slot_wd = kid;
          posm_we = 1'b1; posm_wa = kid;   posm_wd = pos_q;
          pos_d   = kpos;
        end
      end
      S_D3: begin
        if (!sink_stop) begin
          slot_we = 1'b1; slot_wa = pos_q; slot_wd = kid;
          posm_we = 1'b1; posm_wa = kid;   posm_wd = pos_q;
          pos_d   = kpos;
        end
      end
      S_PLACE: begin
        slot_we = 1'b1; slot_wa = pos_q; slot_wd = h_q;
        posm_we = 1'b1; posm_wa = h_q;   posm_wd = pos_q;
      end
      S_MIN0: begin
        slot_ra = '0;
        if (empty) begin
          mk_d = '0;
          mp_d = '0;
        end
      end
      S_MIN1: begin
        key_ra = slot_rd;
        pay_ra = slot_rd;
      end
      S_MIN2: begin
        mk_d = key_rd;
        mp_d = pay_rd;
      end
      default: begin
      end
    endcase
  end

  // Output register lets the next command start while a result waits.
  always_comb begin
    ov_d  = ov_q;
    otd_d = otd_q;
    otu_d = otu_q;
    if (m_axis_tvalid && m_axis_tready) ov_d = 1'b0;
    if (load) begin
      ov_d  = 1'b1;
      otu_d = st_q;
      otd_d = {2'b00, mp_q, mk_q, empty, count_q, ok_q, op_q, oh_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      fresh_q <= '0;
      fstk_q  <= '0;
      ov_q    <= 1'b0;
      moved_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      fresh_q <= fresh_d;
      fstk_q  <= fstk_d;
      ov_q    <= ov_d;
      moved_q <= moved_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d;  hin_q <= hin_d;  kin_q <= kin_d;  pin_q <= pin_d;
    h_q <= h_d;  k_q <= k_d;  pos_q <= pos_d;  ph_q <= ph_d;
    lh_q <= lh_d;  rh_q <= rh_d;  lk_q <= lk_d;
    st_q <= st_d;  oh_q <= oh_d;  ok_q <= ok_d;  op_q <= op_d;
    mk_q <= mk_d;  mp_q <= mp_d;
    otd_q <= otd_d;  otu_q <= otu_d;
  end

  assign m_axis_tvalid = ov_q;
  assign m_axis_tdata  = otd_q;
  assign m_axis_tuser  = otu_q;

`ifndef SYNTHESIS
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("node count above capacity");
  a_handle_books: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> {1'b0, fresh_q} == {1'b0, count_q} + {1'b0, fstk_q})
    else $error("issued handles do not match live plus freed");
  a_rise_root: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_R2 && !par_le) |=> moved_q)
    else $error("sift-up move not recorded");
`endif

endmodule

@@ rtl/imhq_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
